// ===== design/assert_macros.svh =====
// Assertion macros shared by the RTL. Simulation gets the checks, synthesis gets nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/owubef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package owubef_pkg;

   typedef enum logic [2:0] {
      OP_HOST_WRITE = 3'd0,
      OP_HOST_READ  = 3'd1,
      OP_RX_CLEAR   = 3'd2,
      OP_LINE_RX    = 3'd3,
      OP_TX_EMPTY   = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   localparam logic [7:0] ECHO_MAX   = 8'hFF;
   localparam logic [7:0] ECHO_RESET = 8'h01;

endpackage

`default_nettype wire

// ===== design/owubef_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owubef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/owubef_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module owubef_fifo #(
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       push,
   input  wire logic                       pop,
   input  wire logic                       clear,
   input  wire logic [7:0]                 push_data,
   output logic      [7:0]                 head_data,
   output logic      [$clog2(DEPTH+1)-1:0] count,
   output owubef_pkg::fifo_status_type     status
);

   import owubef_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (clear) begin
         head_in  = '0;
         tail_in  = '0;
         count_in = '0;
      end else begin
         if (push) begin
            tail_in = (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
         end
         if (pop) begin
            head_in = (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
         end
         if (push && !pop) begin
            count_in = count_ff + 1'b1;
         end else if (pop && !push) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   owubef_ram #(
      .WIDTH(8),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (push && !clear),
      .wr_addr(tail_ff),
      .wr_data(push_data),
      .rd_addr(head_ff),
      .rd_data(head_data)
   );

   assign count        = count_ff;
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

// ===== design/one_wire_uart_buffer_echo_filter.sv =====
// Half-duplex one-wire UART buffer with a transmit FIFO, a receive FIFO and echo suppression.
// Request channel: an event (host write, host read, clear receive, line byte received,
// transmitter empty) is taken at a rising edge with start high and busy low, together with
// req_data and req_line_overrun. Busy is high in the cycle after that edge.
// Result channel: each event gives exactly one result, shown for one cycle with rsp_valid high,
// in the cycle after the busy cycle. The fill counts, flags, interrupt enables and echo count
// on the rsp_ ports show the state after that event. The receiver cannot stall the block.
// No new event is taken while busy, since the FIFO memories have a registered read port, read at
// the head pointer in the accept cycle and updated in the busy cycle.
// Configuration: csr_write_enable with csr_write_data sets echo suppression; write it only while
// the block is idle.
// Reset empties both FIFOs, sets the echo count to one, clears the overrun flag, enables the
// receive interrupt, disables the transmit interrupt and turns echo suppression on. The FIFO
// memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module one_wire_uart_buffer_echo_filter #(
   parameter int RX_DEPTH = 64,
   parameter int TX_DEPTH = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [2:0] req_operation,
   input  wire logic [7:0] req_data,
   input  wire logic       req_line_overrun,
   input  wire logic       csr_write_enable,
   input  wire logic       csr_write_data,
   output logic            rsp_valid,
   output logic            rsp_write_accepted,
   output logic      [7:0] rsp_read_data,
   output logic            rsp_read_valid,
   output logic            rsp_line_send,
   output logic      [7:0] rsp_line_byte,
   output logic      [6:0] rsp_rx_fill,
   output logic      [6:0] rsp_tx_fill,
   output logic            rsp_overrun_seen,
   output logic            rsp_tx_irq_on,
   output logic            rsp_rx_irq_on,
   output logic      [7:0] rsp_echo_pending
);

   import owubef_pkg::*;

   localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
   localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

   state_type state_ff, state_in;
   logic [2:0] op_ff;
   logic [7:0] data_ff;
   logic       ovr_ff;
   logic       echo_en_ff;
   logic [7:0] echo_ff, echo_in;
   logic       overrun_ff, overrun_in;
   logic       tx_irq_ff, tx_irq_in;
   logic       rx_irq_ff, rx_irq_in;

   logic       rsp_valid_ff;
   logic       wr_ok_ff, wr_ok_in;
   logic [7:0] rd_data_ff, rd_data_in;
   logic       rd_valid_ff, rd_valid_in;
   logic       send_ff, send_in;
   logic [7:0] send_byte_ff, send_byte_in;

   logic rx_push, rx_pop, rx_clear;
   logic tx_push, tx_pop;
   logic [7:0] rx_head_data, tx_head_data;
   logic [RX_CNT_W-1:0] rx_count;
   logic [TX_CNT_W-1:0] tx_count;
   fifo_status_type rx_status, tx_status;

   logic accept, exec;

   assign accept = start && (state_ff == ST_IDLE);
   assign exec   = (state_ff == ST_EXEC);
   assign busy   = exec;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      echo_in      = echo_ff;
      overrun_in   = overrun_ff;
      tx_irq_in    = tx_irq_ff;
      rx_irq_in    = rx_irq_ff;
      wr_ok_in     = 1'b0;
      rd_data_in   = '0;
      rd_valid_in  = 1'b0;
      send_in      = 1'b0;
      send_byte_in = '0;
      rx_push      = 1'b0;
      rx_pop       = 1'b0;
      rx_clear     = 1'b0;
      tx_push      = 1'b0;
      tx_pop       = 1'b0;
      if (exec) begin
         case (op_ff)
            OP_HOST_WRITE: begin
               if (!tx_status.full) begin
                  tx_push  = 1'b1;
                  wr_ok_in = 1'b1;
                  if (!tx_irq_ff) begin
                     tx_irq_in = 1'b1;
                     rx_irq_in = 1'b0;
                  end
               end
            end
            OP_HOST_READ: begin
               if (!rx_status.empty) begin
                  rx_pop      = 1'b1;
                  rd_valid_in = 1'b1;
                  rd_data_in  = rx_head_data;
               end
            end
            OP_RX_CLEAR: begin
               rx_clear = 1'b1;
            end
            OP_LINE_RX: begin
               if (ovr_ff) begin
                  overrun_in = 1'b1;
               end else if (echo_ff != '0) begin
                  echo_in = echo_ff - 1'b1;
               end else if (!rx_status.full) begin
                  rx_push = 1'b1;
               end else begin
                  overrun_in = 1'b1;
               end
            end
            OP_TX_EMPTY: begin
               if (!tx_status.empty) begin
                  if (echo_en_ff && (echo_ff != ECHO_MAX)) begin
                     echo_in = echo_ff + 1'b1;
                  end
                  tx_pop       = 1'b1;
                  send_in      = 1'b1;
                  send_byte_in = tx_head_data;
               end else begin
                  tx_irq_in = 1'b0;
                  rx_irq_in = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         echo_en_ff   <= 1'b1;
         echo_ff      <= ECHO_RESET;
         overrun_ff   <= 1'b0;
         tx_irq_ff    <= 1'b0;
         rx_irq_ff    <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         echo_ff      <= echo_in;
         overrun_ff   <= overrun_in;
         tx_irq_ff    <= tx_irq_in;
         rx_irq_ff    <= rx_irq_in;
         rsp_valid_ff <= exec;
         if (csr_write_enable) begin
            echo_en_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= req_operation;
         data_ff <= req_data;
         ovr_ff  <= req_line_overrun;
      end
      if (exec) begin
         wr_ok_ff     <= wr_ok_in;
         rd_data_ff   <= rd_data_in;
         rd_valid_ff  <= rd_valid_in;
         send_ff      <= send_in;
         send_byte_ff <= send_byte_in;
      end
   end

   owubef_fifo #(
      .DEPTH(RX_DEPTH)
   ) u_rx_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (rx_push),
      .pop      (rx_pop),
      .clear    (rx_clear),
      .push_data(data_ff),
      .head_data(rx_head_data),
      .count    (rx_count),
      .status   (rx_status)
   );

   owubef_fifo #(
      .DEPTH(TX_DEPTH)
   ) u_tx_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (tx_push),
      .pop      (tx_pop),
      .clear    (1'b0),
      .push_data(data_ff),
      .head_data(tx_head_data),
      .count    (tx_count),
      .status   (tx_status)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_write_accepted = wr_ok_ff;
   assign rsp_read_data      = rd_data_ff;
   assign rsp_read_valid     = rd_valid_ff;
   assign rsp_line_send      = send_ff;
   assign rsp_line_byte      = send_byte_ff;
   assign rsp_rx_fill        = 7'(rx_count);
   assign rsp_tx_fill        = 7'(tx_count);
   assign rsp_overrun_seen   = overrun_ff;
   assign rsp_tx_irq_on      = tx_irq_ff;
   assign rsp_rx_irq_on      = rx_irq_ff;
   assign rsp_echo_pending   = echo_ff;

   `ASSERT_NEXT(a_accept_busy, clock, reset, accept, busy && !rsp_valid)
   `ASSERT_NEXT(a_exec_result, clock, reset, exec, rsp_valid && !busy)
   `ASSERT_ALWAYS(a_irq_swap, clock, reset, tx_irq_ff != rx_irq_ff)
   `ASSERT_IMPLIES(a_one_pop, clock, reset, rsp_valid, !(rd_valid_ff && send_ff))
   `ASSERT_ALWAYS(a_rx_bound, clock, reset, rx_count <= RX_CNT_W'(RX_DEPTH))

endmodule

`default_nettype wire
